// ===== rtl/sat_pkg.sv =====
// Package for the shell argument tokenizer.
// Holds the byte constants, quote state codes and the step result struct.
// No dependencies.
package sat_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef logic [1:0] quote_kind_t;
	localparam quote_kind_t QK_NONE   = 2'd0;
	localparam quote_kind_t QK_SINGLE = 2'd1;
	localparam quote_kind_t QK_DOUBLE = 2'd2;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned PtrW      = $clog2(FifoDepth);
	localparam int unsigned CntW      = $clog2(FifoDepth + 1);

	typedef struct packed {
		logic [7:0] ch;
		logic       kind;
	} token_t;

	typedef struct packed {
		quote_kind_t quote_kind;
		logic        escape_pending;
		logic        token_open;
	} tok_state_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     r0;
		token_t     r1;
		tok_state_t nxt;
	} step_res_t;

endpackage

// ===== rtl/shell_argument_tokenizer.sv =====
// Top level of the shell-style argument tokenizer.
// Instantiates sat_step and sat_result_fifo; uses sat_pkg.
//
// channel | direction | signals                              | payload
// --------+-----------+--------------------------------------+--------------------------------
// in      | sink      | in_valid / in_ready                  | in_char[7:0], is_end
// out     | source    | out_valid / out_ready                | out_char[7:0], out_kind, last_of_run
// cfg     | sink      | cfg_valid / cfg_ready                | cfg_data[1:0] (mode_flags)
//
// One byte per cycle while the queue has room: a byte is registered, classified
// in the next cycle and its zero to two tokens go into a four-entry result queue.
// The out port drains one token per cycle while out_ready is high.
// The input stage advances only while the queue has at least two free entries.
// Reset clears the tokenizer state, mode_flags and the queue pointers.
// cfg_ready is always high.
module shell_argument_tokenizer import sat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       is_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_kind,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            end_s1;
	logic [1:0]      mode_q;
	tok_state_t      state_q;
	step_res_t       res;
	logic            adv_s1;
	logic [CntW-1:0] fifo_cnt;
	token_t          head;
	logic            head_last;
	logic            pop;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (fifo_cnt <= CntW'(FifoDepth - 2));
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= 2'b00;
			state_q  <= '{quote_kind: QK_NONE, escape_pending: 1'b0, token_open: 1'b0};
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (adv_s1) begin
				state_q <= res.nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
			end_s1  <= is_end;
		end
	end

	sat_step u_step (
		.ch         (char_s1),
		.is_end     (end_s1),
		.mode_flags (mode_q),
		.cur        (state_q),
		.res        (res)
	);

	sat_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv_s1),
		.push_n    (res.n),
		.push_r0   (res.r0),
		.push_r1   (res.r1),
		.count     (fifo_cnt),
		.pop       (pop),
		.head      (head),
		.head_last (head_last)
	);

	assign out_valid   = (fifo_cnt != '0);
	assign pop         = out_valid && out_ready;
	assign out_char    = head.ch;
	assign out_kind    = head.kind;
	assign last_of_run = head_last;

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= CntW'(FifoDepth))
		else $error("result queue over capacity");

	// only end of string can produce two tokens
	a_two_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res.n == 2'd2) |-> end_s1)
		else $error("two tokens from a non-end byte");

	// end of string returns the tokenizer to its idle state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && end_s1) |=> (state_q.quote_kind == QK_NONE
			&& !state_q.escape_pending && !state_q.token_open))
		else $error("state not cleared after end of string");

	// empty input stage always takes a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while stage empty");

	// a token was pushed means output is offered next cycle
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.n != 2'd0) |=> out_valid)
		else $error("pushed token not visible");

endmodule

// ===== rtl/sat_step.sv =====
// Per-byte tokenizer step: classifies one byte against the current state.
// Produces up to two output tokens and the next state.
// Depends on sat_pkg.
module sat_step import sat_pkg::*; (
	input  logic [7:0] ch,
	input  logic       is_end,
	input  logic [1:0] mode_flags,
	input  tok_state_t cur,
	output step_res_t  res
);

	logic        quotes_on;
	logic        escape_on;
	logic        is_space;
	logic        is_quote;
	quote_kind_t kind;

	assign quotes_on = ~mode_flags[0];
	assign escape_on = ~mode_flags[1];
	assign is_space  = ch inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};
	assign is_quote  = (ch == CH_SQUOTE) || (ch == CH_DQUOTE);
	assign kind      = (ch == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;

	always_comb begin
		res.n   = 2'd0;
		res.r0  = '{ch: ch, kind: KIND_BYTE};
		res.r1  = '{ch: 8'h00, kind: KIND_END};
		res.nxt = cur;
		if (is_end) begin
			// pending backslash flushes as a literal byte, then the argument closes
			if (cur.escape_pending) begin
				res.r0 = '{ch: CH_BSLASH, kind: KIND_BYTE};
				res.n  = 2'd2;
			end else if (cur.token_open) begin
				res.r0 = '{ch: 8'h00, kind: KIND_END};
				res.n  = 2'd1;
			end
			res.nxt = '{quote_kind: QK_NONE, escape_pending: 1'b0, token_open: 1'b0};
		end else if (cur.escape_pending) begin
			res.nxt.escape_pending = 1'b0;
			res.nxt.token_open     = 1'b1;
			res.n                  = 2'd1;
		end else if (is_space && cur.quote_kind == QK_NONE) begin
			if (cur.token_open) begin
				res.r0             = '{ch: 8'h00, kind: KIND_END};
				res.n              = 2'd1;
				res.nxt.token_open = 1'b0;
			end
		end else if (quotes_on && is_quote) begin
			if (cur.quote_kind == QK_NONE) begin
				res.nxt.quote_kind = kind;
				res.nxt.token_open = 1'b1;
			end else if (cur.quote_kind == kind) begin
				res.nxt.quote_kind = QK_NONE;
			end else begin
				res.nxt.token_open = 1'b1;
				res.n              = 2'd1;
			end
		end else if (escape_on && ch == CH_BSLASH) begin
			res.nxt.escape_pending = 1'b1;
			res.nxt.token_open     = 1'b1;
		end else begin
			res.nxt.token_open = 1'b1;
			res.n              = 2'd1;
		end
	end

endmodule

// ===== rtl/sat_result_fifo.sv =====
// Small result queue: takes up to two tokens per cycle, hands out one.
// Marks the final token of each input transaction.
// Depends on sat_pkg.
module sat_result_fifo import sat_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [1:0]      push_n,
	input  token_t          push_r0,
	input  token_t          push_r1,
	output logic [CntW-1:0] count,
	input  logic            pop,
	output token_t          head,
	output logic            head_last
);

	token_t          tok_q  [FifoDepth];
	logic            last_q [FifoDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic [1:0]      n_eff;
	logic [PtrW-1:0] wr_p1;

	assign n_eff     = push ? push_n : 2'd0;
	assign wr_p1     = wr_q + PtrW'(1);
	assign count     = cnt_q;
	assign head      = tok_q[rd_q];
	assign head_last = last_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PtrW'(n_eff);
			if (pop) begin
				rd_q <= rd_q + PtrW'(1);
			end
			cnt_q <= cnt_q + CntW'(n_eff) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_eff != 2'd0) begin
			tok_q[wr_q]  <= push_r0;
			last_q[wr_q] <= (n_eff == 2'd1);
		end
		if (n_eff == 2'd2) begin
			tok_q[wr_p1]  <= push_r1;
			last_q[wr_p1] <= 1'b1;
		end
	end

endmodule
